// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== src/glpf_pkg.sv =====
// ----------------------------------------------------------------------------
// glpf_pkg
// Shared widths, register indexes and helpers for the grid peak finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package glpf_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int SAMPLE_BITS = 16;

	localparam int DIM_W = 11;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
	localparam int OUT_W = 10;
	localparam int IDX_W = 1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [DIM_W-1:0]              dim_t;
	typedef logic [COL_W-1:0]              col_t;
	typedef logic [ROW_W-1:0]              row_t;
	typedef logic [OUT_W-1:0]              coord_t;
	typedef logic [IDX_W-1:0]              reg_idx_t;

	typedef enum logic [IDX_W-1:0] {
		REG_GRID_HEIGHT = 1'b0,
		REG_GRID_WIDTH  = 1'b1
	} reg_sel_t;

	localparam dim_t DIM_ONE = dim_t'(1);

	// saturate a dimension to 1..hi
	function automatic dim_t clamp_dim(input dim_t value, input dim_t hi);
		dim_t res;
		if (value < DIM_ONE) begin
			res = DIM_ONE;
		end else if (value > hi) begin
			res = hi;
		end else begin
			res = value;
		end
		return res;
	endfunction

endpackage

// ===== src/grid_local_peak_finder_unit.sv =====
// ----------------------------------------------------------------------------
// grid_local_peak_finder_unit
// Four-neighbour local maximum detector on a raster-ordered signed grid.
// ----------------------------------------------------------------------------
//
//  port group | direction | word contents
//  -----------+-----------+-------------------------------------------
//  in_*       | sink      | req_type, cell_value
//  out_*      | source    | peak_row, peak_col
//  cfg_*      | sink      | cfg_index (0 height, 1 width), cfg_data
//
//  One word per cycle sustained unless a held result stalls stage 1; a peak
//  goes to out_* through stage 1, which holds its deciding word, and then
//  the result register, which loads when stage 1 advances.
//  The line buffer is one 1024 x 32 dual-port array (current and previous
//  row); its single read port is what fixes the rate at one word per cycle.
//  Reset sets both dimensions to one and clears the frame counters and valids
//  only; line contents start undefined and need no clearing pass.
//  A held result blocks the stage only while the stage holds another peak.
//
`timescale 1ns / 1ps
`include "assert_macros.svh"

module grid_local_peak_finder_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     req_type,
	input  glpf_pkg::sample_t        cell_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output glpf_pkg::coord_t         peak_row,
	output glpf_pkg::coord_t         peak_col,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  glpf_pkg::reg_idx_t       cfg_index,
	input  glpf_pkg::dim_t           cfg_data
);
	import glpf_pkg::*;

	localparam dim_t MAX_W_DIM = dim_t'(MAX_WIDTH);
	localparam dim_t MAX_H_DIM = dim_t'(MAX_HEIGHT);

	// configuration (stored already clamped)
	dim_t h_q, w_q;
	// frame position of the next word
	row_t row_q;
	col_t col_q;

	// stage 1
	logic    valid_s1;
	sample_t v_s1;
	row_t    r_s1;
	col_t    c_s1;
	logic    last_s1;
	logic    self_s1;
	logic    fwd_s1;

	// column window: value and up of the column now in stage 1, left neighbor
	sample_t win_cand_q, win_up_q, left_q;
	sample_t fwd_p_q, fwd_s_q;

	logic [2*SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];
	logic [2*SAMPLE_BITS-1:0] rd_q;

	logic     out_valid_q;
	coord_t   peak_row_q, peak_col_q;

	logic     in_fire, cfg_fire, adv, peak;
	dim_t     col_inc;
	logic     last_col;
	col_t     nc;
	sample_t  v_in;
	sample_t  rd_p, rd_s, up, left, right;
	row_t     r_minus;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;
	assign in_fire   = in_valid & in_ready;

	assign col_inc  = {1'b0, col_q} + DIM_ONE;
	assign last_col = (col_inc == w_q);
	assign nc       = last_col ? '0 : col_inc[COL_W-1:0];
	assign v_in     = (req_type || ({1'b0, row_q} >= {1'b0, h_q})) ? '0 : cell_value;

	always_comb begin
		if (self_s1) begin
			rd_p = v_s1;
			rd_s = win_cand_q;
		end else if (fwd_s1) begin
			rd_p = fwd_p_q;
			rd_s = fwd_s_q;
		end else begin
			rd_p = sample_t'(rd_q[2*SAMPLE_BITS-1:SAMPLE_BITS]);
			rd_s = sample_t'(rd_q[SAMPLE_BITS-1:0]);
		end
		up    = (r_s1 >= row_t'(2)) ? win_up_q : '0;
		left  = (c_s1 != '0) ? left_q : '0;
		right = last_s1 ? '0 : rd_p;
		peak  = (r_s1 != '0) && (win_cand_q >= up) && (win_cand_q >= v_s1)
			&& (win_cand_q >= left) && (win_cand_q >= right);
		adv     = valid_s1 && (!peak || !out_valid_q || out_ready);
		r_minus = r_s1 - row_t'(1);
	end

	assign in_ready = !valid_s1 || adv;

	// config and frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q   <= DIM_ONE;
			w_q   <= DIM_ONE;
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_fire) begin
			unique case (reg_sel_t'(cfg_index))
				REG_GRID_HEIGHT: h_q <= clamp_dim(cfg_data, MAX_H_DIM);
				REG_GRID_WIDTH:  w_q <= clamp_dim(cfg_data, MAX_W_DIM);
				default:         h_q <= h_q;
			endcase
			row_q <= '0;
			col_q <= '0;
		end else if (in_fire) begin
			col_q <= nc;
			if (last_col) begin
				row_q <= (row_q == h_q[ROW_W-1:0]) ? '0 : row_q + row_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			v_s1    <= v_in;
			r_s1    <= row_q;
			c_s1    <= col_q;
			last_s1 <= last_col;
			self_s1 <= (nc == col_q);
			fwd_s1  <= adv && (c_s1 == nc);
			fwd_p_q <= v_s1;
			fwd_s_q <= win_cand_q;
		end
		if (adv) begin
			win_cand_q <= rd_p;
			win_up_q   <= rd_s;
			left_q     <= win_cand_q;
		end
	end

	// line buffer: {row r-1, row r-2} per column
	always_ff @(posedge clk) begin
		if (adv) begin
			line_mem[c_s1] <= {v_s1, win_cand_q};
		end
		if (in_fire) begin
			rd_q <= line_mem[nc];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && peak) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && peak) begin
			peak_row_q <= r_minus[OUT_W-1:0];
			peak_col_q <= c_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign peak_row  = peak_row_q;
	assign peak_col  = peak_col_q;

	`ASSERT_CLK(a_col_in_range, clk, arst_n, ({1'b0, col_q} < w_q), "column past grid width")
	`ASSERT_CLK(a_row_in_range, clk, arst_n, (row_q <= h_q[ROW_W-1:0]), "row past grid height")
	`ASSERT_CLK(a_cfg_restart, clk, arst_n, cfg_fire |=> (row_q == '0 && col_q == '0), "config did not restart frame")
	`ASSERT_NEVER(a_self_fwd_width, clk, arst_n, valid_s1 && self_s1 && (w_q != DIM_ONE), "self forward with wide grid")

endmodule

// ===== bench/grid_local_peak_finder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// grid_local_peak_finder_unit_tb
// Sends whole and broken raster frames to the peak finder and scores each peak
// word against a line-buffer predictor. The predictor is updated at every
// accepted cell word and every register write. Directed frames cover the
// sample extremes, flush words inside the grid, samples in the zero row and
// plateaus. Further runs cover the dimension extremes and clamping, a long
// result stall and random frames. The sender works in bursts and the receiver
// stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_local_peak_finder_unit_tb;
	import glpf_pkg::*;

	localparam int LIMIT_CYCLES  = 1000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_WORDS  = 380;

	typedef struct packed {
		coord_t row;
		coord_t col;
	} peak_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	logic     req_type;
	sample_t  cell_value;
	logic     out_valid;
	logic     out_ready;
	coord_t   peak_row;
	coord_t   peak_col;
	logic     cfg_valid;
	logic     cfg_ready;
	reg_idx_t cfg_index;
	dim_t     cfg_data;

	// predictor state
	dim_t    grid_h_reg;
	dim_t    grid_w_reg;
	int      row_pos;
	int      col_pos;
	sample_t left_val;
	sample_t line_prev [MAX_WIDTH];
	sample_t line_prev2 [MAX_WIDTH];
	peak_t   pending_peaks [$];

	int fail_count;
	int words_sent;
	int words_taken;
	int peaks_checked;
	int reg_writes;

	int burst_left;
	bit sender_steady;

	int       hold_req;
	int       hold_left;
	int       mode_left;
	int       rx_phase;
	rx_mode_t rx_mode;

	grid_local_peak_finder_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.cell_value (cell_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.peak_row   (peak_row),
		.peak_col   (peak_col),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	task automatic apply_reg(input reg_idx_t idx, input dim_t data);
		if (reg_sel_t'(idx) == REG_GRID_HEIGHT) begin
			grid_h_reg = data;
		end else begin
			grid_w_reg = data;
		end
		row_pos  = 0;
		col_pos  = 0;
		left_val = '0;
	endtask

	task automatic track_word(input logic rt, input sample_t v);
		int      h;
		int      w;
		int      r;
		int      c;
		sample_t cur;
		sample_t cand;
		sample_t up;
		sample_t lf;
		sample_t rt_val;
		peak_t   pk;
		h = (grid_h_reg == 0) ? 1 : ((grid_h_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(grid_h_reg));
		w = (grid_w_reg == 0) ? 1 : ((grid_w_reg > MAX_WIDTH) ? MAX_WIDTH : int'(grid_w_reg));
		r = (row_pos > h) ? h : row_pos;
		c = (col_pos >= w) ? w - 1 : col_pos;
		cur = (rt || r >= h) ? sample_t'(0) : v;
		if (r >= 1) begin
			cand   = line_prev[c];
			up     = (r >= 2) ? line_prev2[c] : sample_t'(0);
			lf     = (c > 0) ? left_val : sample_t'(0);
			rt_val = (c + 1 < w) ? line_prev[c+1] : sample_t'(0);
			if (cand >= up && cand >= cur && cand >= lf && cand >= rt_val) begin
				pk.row = coord_t'(r - 1);
				pk.col = coord_t'(c);
				pending_peaks.push_back(pk);
			end
			left_val = cand;
		end
		line_prev2[c] = line_prev[c];
		line_prev[c]  = cur;
		c++;
		if (c >= w) begin
			c        = 0;
			left_val = '0;
			r++;
			if (r > h) begin
				r = 0;
			end
		end
		row_pos = r;
		col_pos = c;
	endtask

	always @(posedge clk) begin : scoreboard
		peak_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				apply_reg(cfg_index, cfg_data);
			end
			if (in_valid && in_ready) begin
				track_word(req_type, cell_value);
				words_taken++;
			end
			if (out_valid && out_ready) begin
				if (pending_peaks.size() == 0) begin
					$error("unexpected peak word: row %0d col %0d", peak_row, peak_col);
					fail_count++;
				end else begin
					want = pending_peaks.pop_front();
					peaks_checked++;
					if (peak_row !== want.row) begin
						$error("peak_row mismatch: expected %0d, actual %0d", want.row, peak_row);
						fail_count++;
					end
					if (peak_col !== want.col) begin
						$error("peak_col mismatch: expected %0d, actual %0d", want.col, peak_col);
						fail_count++;
					end
				end
			end
		end
	end

	// receiver stall pattern, with long hold-offs on request
	always @(negedge clk) begin
		rx_phase++;
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (mode_left == 0) begin
			rx_mode   = rx_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN: begin
					out_ready <= 1'b1;
				end
				RX_COIN: begin
					out_ready <= 1'($urandom_range(0, 1));
				end
				RX_SPARSE: begin
					out_ready <= ($urandom_range(0, 3) == 0);
				end
				default: begin
					out_ready <= (rx_phase % 7) < 3;
				end
			endcase
		end
	end

	function automatic sample_t pick_value();
		int sel;
		int tmp;
		sel = $urandom_range(0, 3);
		tmp = $urandom_range(0, 4);
		case (sel)
			0: return sample_t'($urandom);
			1: return sample_t'(tmp - 2);
			2: return ($urandom_range(0, 1) != 0) ? sample_t'(16'h7FFF) : sample_t'(16'h8000);
			default: return sample_t'($urandom_range(0, 40) - 20);
		endcase
	endfunction

	task automatic push_word(input logic rt, input sample_t v);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = sender_steady ? 0 :
				(($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 6));
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		in_valid   <= 1'b1;
		req_type   <= rt;
		cell_value <= v;
		burst_left--;
		words_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid, wait for every expected peak, then cover trailing latency
	task automatic settle_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_peaks.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_sel_t sel, input dim_t val);
		settle_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_dims(input dim_t h, input dim_t w);
		write_reg(REG_GRID_HEIGHT, h);
		write_reg(REG_GRID_WIDTH, w);
	endtask

	// h grid rows plus the zero row; cut_at >= 0 stops the frame early
	task automatic send_frame(input int h, input int w, input int cut_at, input int noise_pct);
		int  idx;
		bit  flip;
		idx = 0;
		for (int r = 0; r <= h; r++) begin
			for (int c = 0; c < w; c++) begin
				if (cut_at >= 0 && idx >= cut_at) begin
					return;
				end
				flip = ($urandom_range(0, 99) < noise_pct);
				push_word((r == h) ^ flip, pick_value());
				idx++;
			end
		end
	endtask

	task automatic test_directed_extremes();
		set_dims(dim_t'(3), dim_t'(3));
		push_word(1'b0, sample_t'(16'h7FFF));
		push_word(1'b0, sample_t'(16'h8000));
		push_word(1'b0, sample_t'(0));
		push_word(1'b1, sample_t'(16'h7FFF));  // flush inside grid counts as zero
		push_word(1'b0, sample_t'(100));
		push_word(1'b0, sample_t'(-1));
		push_word(1'b0, sample_t'(16'h8000));
		push_word(1'b0, sample_t'(5));
		push_word(1'b0, sample_t'(16'h7FFF));
		push_word(1'b1, sample_t'(0));
		push_word(1'b0, sample_t'(12345));     // sample in zero row is ignored
		push_word(1'b1, sample_t'(16'h8000));
	endtask

	task automatic test_plateau();
		set_dims(dim_t'(2), dim_t'(2));
		for (int i = 0; i < 6; i++) begin
			push_word(i >= 4, sample_t'(7));
		end
	endtask

	// full-width row plus the start of the zero row; tall grid only started
	task automatic test_dim_extremes();
		set_dims(dim_t'(0), dim_t'(0));
		send_frame(1, 1, -1, 0);
		send_frame(1, 1, -1, 50);
		set_dims(dim_t'(2047), dim_t'(1));
		send_frame(1024, 1, 24, 2);
		set_dims(dim_t'(1), dim_t'(1025));
		send_frame(1, 1024, 1024 + 24, 2);
	endtask

	task automatic test_backpressure();
		set_dims(dim_t'(8), dim_t'(8));
		sender_steady = 1'b1;
		hold_req = 400;
		for (int i = 0; i < 72; i++) begin
			if (i == 36) begin
				settle_idle();
			end
			push_word(i >= 64, sample_t'(9));
		end
		sender_steady = 1'b0;
	endtask

	task automatic test_random_frames();
		int h;
		int w;
		int cut;
		bit was_cut;
		int start;
		h       = 1;
		w       = 1;
		was_cut = 1'b1;
		start   = words_sent;
		while (words_sent - start < RANDOM_WORDS) begin
			if (was_cut || $urandom_range(0, 2) != 0) begin
				h = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				w = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				set_dims(dim_t'(h), dim_t'(w));
			end
			sender_steady = ($urandom_range(0, 3) == 0);
			cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, (h + 1) * w - 1) : -1;
			was_cut = (cut >= 0);
			send_frame(h, w, cut, ($urandom_range(0, 3) == 0) ? 15 : 0);
		end
		sender_steady = 1'b0;
	endtask

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("grid_local_peak_finder_unit verification failed");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		req_type      = 1'b0;
		cell_value    = '0;
		out_ready     = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		grid_h_reg    = dim_t'(1);
		grid_w_reg    = dim_t'(1);
		row_pos       = 0;
		col_pos       = 0;
		left_val      = '0;
		fail_count    = 0;
		words_sent    = 0;
		words_taken   = 0;
		peaks_checked = 0;
		reg_writes    = 0;
		burst_left    = 0;
		sender_steady = 1'b0;
		hold_req      = 0;
		hold_left     = 0;
		mode_left     = 0;
		rx_phase      = 0;
		rx_mode       = RX_OPEN;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			line_prev[i]  = '0;
			line_prev2[i] = '0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_extremes();
		test_plateau();
		test_dim_extremes();
		test_backpressure();
		test_random_frames();
		settle_idle();

		$display("run: %0d cell/flush words accepted, %0d peaks checked, %0d register writes",
			words_taken, peaks_checked, reg_writes);
		$display("frames: directed extremes, plateau, size limits and clamping, stall, random");
		if (fail_count == 0) begin
			$display("grid_local_peak_finder_unit verification clean");
		end else begin
			$display("grid_local_peak_finder_unit verification failed");
		end
		$finish;
	end

endmodule

// ===== grid_local_peak_finder_unit.f =====
+incdir+src
src/glpf_pkg.sv
src/grid_local_peak_finder_unit.sv
bench/grid_local_peak_finder_unit_tb.sv
